[design/base85_byte_to_printable_encoder_macros.svh]
// ----------------------------------------------------------------------------
// Base85 encoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef BASE85_BYTE_TO_PRINTABLE_ENCODER_MACROS_SVH
`define BASE85_BYTE_TO_PRINTABLE_ENCODER_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on that edge.
`define B85_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define B85_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/b85_pkg.sv]
// ----------------------------------------------------------------------------
// Base85 encoder package
// Widths, the divide-by-85 reciprocal, the alphabet lookup and the load
// command passed from the byte gatherer to the character emitter.
// ----------------------------------------------------------------------------
package b85_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned GroupW = 24;
  localparam int unsigned FillW  = 2;
  localparam int unsigned CountW = 3;
  localparam int unsigned LimitW = 16;
  localparam int unsigned CharW  = 7;
  localparam int unsigned DigitW = 7;
  localparam int unsigned QuotW  = 26;

  localparam logic [CountW-1:0] DigitsPerGroup = 3'd5;
  localparam logic [FillW-1:0]  LastFill       = 2'd3;
  localparam logic [LimitW-1:0] LimitReset     = 16'd40;

  // floor(n * Recip85 / 2^RecipShift) == floor(n / 85) for every 32-bit n
  localparam logic [WordW-1:0] Recip85    = 32'd3233857729;
  localparam int unsigned      RecipShift = 38;

  localparam int unsigned PunctCount = 23;
  localparam logic [CharW-1:0] PunctChars [PunctCount] = '{
    7'd33, 7'd35, 7'd36, 7'd37, 7'd38, 7'd40, 7'd41, 7'd42,
    7'd43, 7'd45, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64,
    7'd94, 7'd95, 7'd96, 7'd123, 7'd124, 7'd125, 7'd126
  };

  // Group handed to the emitter: padded word, characters to send, buffer end
  typedef struct packed {
    logic                valid;
    logic [WordW-1:0]    word;
    logic [CountW-1:0]   count;
    logic                last;
  } b85_load_t;

  // Map one base-85 digit to its printable character
  function automatic logic [CharW-1:0] b85_char(input logic [DigitW-1:0] digit);
    logic [DigitW-1:0] off;
    off = digit - 7'd62;
    if (digit < 7'd10) begin
      b85_char = 7'd48 + digit;
    end else if (digit < 7'd36) begin
      b85_char = 7'd55 + digit;
    end else if (digit < 7'd62) begin
      b85_char = 7'd61 + digit;
    end else if (off < 7'(PunctCount)) begin
      b85_char = PunctChars[off[4:0]];
    end else begin
      b85_char = PunctChars[PunctCount-1];
    end
  endfunction

endpackage

[design/b85_emit.sv]
// ----------------------------------------------------------------------------
// Base85 character emitter
// Holds one padded word and sends its base-85 digits least significant
// first, one character per beat, dividing by 85 after each beat.
// ----------------------------------------------------------------------------
module b85_emit
  import b85_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  b85_load_t        load_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CharW-1:0] out_char_o,
  output logic             group_last_o,
  output logic             buffer_last_o
);

  logic [WordW-1:0]   cur_q, cur_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               last_q, last_d;
  logic [2*WordW-1:0] prod;
  logic [QuotW-1:0]   quot;
  logic [WordW-1:0]   quot_w;
  logic [WordW-1:0]   quot85;
  logic [WordW-1:0]   rem_w;
  logic               out_fire;

  // Divide the current value by 85 through the reciprocal
  assign prod   = {32'd0, cur_q} * {32'd0, Recip85};
  assign quot   = prod[2*WordW-1:RecipShift];
  assign quot_w = {6'd0, quot};
  assign quot85 = (quot_w << 6) + (quot_w << 4) + (quot_w << 2) + quot_w;
  assign rem_w  = cur_q - quot85;

  // Present the current digit
  assign out_valid_o   = (cnt_q != '0);
  assign out_char_o    = b85_char(rem_w[DigitW-1:0]);
  assign group_last_o  = (cnt_q == 3'd1);
  assign buffer_last_o = (cnt_q == 3'd1) && last_q;

  assign out_fire = out_valid_o && !out_stall_i;
  assign free_o   = (cnt_q == '0) || ((cnt_q == 3'd1) && !out_stall_i);

  // Load a new group or advance to the next digit
  always_comb begin
    cur_d  = cur_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    if (load_i.valid) begin
      cur_d  = load_i.word;
      cnt_d  = load_i.count;
      last_d = load_i.last;
    end else if (out_fire) begin
      cur_d = quot_w;
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    last_q <= last_d;
  end

endmodule

[design/base85_byte_to_printable_encoder.sv]
// ----------------------------------------------------------------------------
// Base85 byte to printable encoder
// Gathers bytes into 32-bit groups and emits five base-85 characters per
// group, least significant digit first, up to a per-buffer character limit.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  in       | in_valid_i/in_stall_o   | data_byte_i, last_byte_i
//  out      | out_valid_o/out_stall_i | out_char_o, group_last_o, buffer_last_o
//  cfg      | cfg_valid_i/cfg_ready_o | cfg_data_i (output_limit)
//
// Bytes are taken one per cycle unless in_stall_o; the emitter sends one character
// per cycle unless out_stall_i, and the next group is gathered while one is sent.
// A closing byte with characters to send waits while the previous group has
// more than one character left, or while its last one is stalled.
// Reset clears the group fill, the character count and the emitter; the limit
// returns to 40. There is no clearing pass.
// ----------------------------------------------------------------------------
module base85_byte_to_printable_encoder
  import b85_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CharW-1:0]  out_char_o,
  output logic              group_last_o,
  output logic              buffer_last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_data_i
);

  logic [GroupW-1:0] group_q, group_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [LimitW-1:0] chars_q, chars_d;
  logic [LimitW-1:0] limit_q, limit_d;
  logic              completes;
  logic [WordW-1:0]  word;
  logic [LimitW:0]   room;
  logic [CountW-1:0] count;
  logic              need_emit;
  logic              emit_free;
  logic              in_fire;
  b85_load_t         load;

  // Pad the group with zero bytes in the low positions
  assign completes = last_byte_i || (fill_q == LastFill);

  always_comb begin
    case (fill_q)
      2'd0:    word = {data_byte_i, 24'd0};
      2'd1:    word = {group_q[7:0], data_byte_i, 16'd0};
      2'd2:    word = {group_q[15:0], data_byte_i, 8'd0};
      default: word = {group_q, data_byte_i};
    endcase
  end

  // Characters still allowed under the limit, at most one group's worth
  assign room = {1'b0, limit_q} - {1'b0, chars_q};

  always_comb begin
    if (chars_q >= limit_q) begin
      count = '0;
    end else if (room >= 17'(DigitsPerGroup)) begin
      count = DigitsPerGroup;
    end else begin
      count = room[CountW-1:0];
    end
  end

  // Hold the closing byte until the emitter can take the group
  assign need_emit  = completes && (count != '0);
  assign in_stall_o = need_emit && !emit_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign load.valid = in_fire && need_emit;
  assign load.word  = word;
  assign load.count = count;
  assign load.last  = last_byte_i;

  // Gather bytes and track characters sent for the buffer
  always_comb begin
    group_d = group_q;
    fill_d  = fill_q;
    chars_d = chars_q;
    if (in_fire) begin
      if (completes) begin
        group_d = '0;
        fill_d  = '0;
        chars_d = last_byte_i ? '0 : chars_q + LimitW'(count);
      end else begin
        group_d = {group_q[15:0], data_byte_i};
        fill_d  = fill_q + 2'd1;
      end
    end
  end

  // Take limit writes at any time
  assign cfg_ready_o = 1'b1;
  assign limit_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      fill_q  <= '0;
      chars_q <= '0;
      limit_q <= LimitReset;
    end else begin
      group_q <= group_d;
      fill_q  <= fill_d;
      chars_q <= chars_d;
      limit_q <= limit_d;
    end
  end

  b85_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .free_o        (emit_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .group_last_o  (group_last_o),
    .buffer_last_o (buffer_last_o)
  );

endmodule

[design/b85_checker.sv]
// ----------------------------------------------------------------------------
// Base85 encoder port checker
// Watches the result channel of the top level and flags broken beats.
// ----------------------------------------------------------------------------
`include "base85_byte_to_printable_encoder_macros.svh"

module b85_checker
  import b85_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [CharW-1:0] out_char_o,
  input logic             group_last_o,
  input logic             buffer_last_o
);

  // Hold a stalled beat unchanged
  `B85_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_char_o) && $stable(group_last_o) && $stable(buffer_last_o), "stalled result beat changed")

  // Keep characters inside the printable range
  `B85_ASSERT_NOW(a_char_range, out_valid_o, (out_char_o >= 7'd33) && (out_char_o <= 7'd126), "character outside printable range")

  // Close the buffer only on a group's final character
  `B85_ASSERT_NOW(a_buf_in_group, out_valid_o && buffer_last_o, group_last_o, "buffer end without group end")

  // Follow a mid-group beat with the next character at once
  `B85_ASSERT_NEXT(a_group_cont, out_valid_o && !out_stall_i && !group_last_o, out_valid_o, "group ended without its final character")

endmodule

bind base85_byte_to_printable_encoder b85_checker u_b85_checker (.*);
